// ===== rtl/core/r2hsv_pkg.sv =====
// shared types and constants for the rgb to hsv converter
`default_nettype none

package r2hsv_pkg;

    // component precision, all-ones means 1.0
    localparam int COMPONENT_BITS = 16;
    // width of every port field
    localparam int FIELD_BITS     = 16;
    // hue numerator and divisor are below 6 * 2^COMPONENT_BITS
    localparam int HUE_BITS       = COMPONENT_BITS + 3;
    // two front stages plus one stage per quotient bit
    localparam int LATENCY        = COMPONENT_BITS + 2;

    typedef logic [FIELD_BITS-1:0]     t_field;
    typedef logic [COMPONENT_BITS-1:0] t_comp;

    typedef struct packed {
        t_field red;
        t_field green;
        t_field blue;
    } t_hsv_req;

    typedef struct packed {
        t_field hue;
        t_field saturation;
        t_field value;
    } t_hsv_res;

    // which component holds the maximum
    typedef enum logic [1:0] {
        SEC_RED,
        SEC_GREEN,
        SEC_BLUE
    } t_sector;

endpackage

`default_nettype wire

// ===== rtl/core/rgb_to_hsv_convert.sv =====
// rgb to hsv pixel converter, fully pipelined
`default_nettype none

// Converts one rgb pixel per clock into hue, saturation and value. A request
// is taken whenever i_start is high; o_busy is always low because the
// pipeline never stalls. The result for a request appears on o_result with
// o_valid high for one cycle, in request order, and must be captured then.
// Throughput is one pixel per clock. The two dividers (saturation and hue)
// produce one quotient bit per pipeline stage, running side by side after a
// min/max stage and a setup stage. Grey pixels give hue and saturation of
// zero.
module rgb_to_hsv_convert (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_start,
    input  r2hsv_pkg::t_hsv_req i_request,
    output logic                o_busy,
    output logic                o_valid,
    output r2hsv_pkg::t_hsv_res o_result
);

    localparam int CB = r2hsv_pkg::COMPONENT_BITS;
    localparam int HW = r2hsv_pkg::HUE_BITS;

    // one divider stage: remainders, divisors and partial quotients
    typedef struct packed {
        logic                valid;
        logic                grey;
        r2hsv_pkg::t_comp    value;
        logic [HW-1:0]       hrem;
        logic [HW-1:0]       hdiv;
        r2hsv_pkg::t_comp    hq;
        r2hsv_pkg::t_comp    srem;
        r2hsv_pkg::t_comp    slo;
        r2hsv_pkg::t_comp    sq;
    } t_div_stage;

    // ------------------------------------------------------------------
    // stage a: min, max, sector and signed difference for the hue
    // ------------------------------------------------------------------
    r2hsv_pkg::t_comp   w_r, w_g, w_b;
    r2hsv_pkg::t_comp   n_a_max, n_a_min;
    r2hsv_pkg::t_sector n_a_sec;
    logic signed [CB:0] n_a_diff;

    logic               r_a_valid;
    r2hsv_pkg::t_comp   r_a_max, r_a_min;
    r2hsv_pkg::t_sector r_a_sec;
    logic signed [CB:0] r_a_diff;

    assign o_busy = 1'b0;

    // bits above the component width are dropped
    assign w_r = r2hsv_pkg::t_comp'(i_request.red);
    assign w_g = r2hsv_pkg::t_comp'(i_request.green);
    assign w_b = r2hsv_pkg::t_comp'(i_request.blue);

    always_comb begin
        n_a_max = w_r;
        if (w_g > n_a_max) n_a_max = w_g;
        if (w_b > n_a_max) n_a_max = w_b;
        n_a_min = w_r;
        if (w_g < n_a_min) n_a_min = w_g;
        if (w_b < n_a_min) n_a_min = w_b;
        // red wins ties, then green
        if (w_r == n_a_max) begin
            n_a_sec  = r2hsv_pkg::SEC_RED;
            n_a_diff = $signed({1'b0, w_g}) - $signed({1'b0, w_b});
        end else if (w_g == n_a_max) begin
            n_a_sec  = r2hsv_pkg::SEC_GREEN;
            n_a_diff = $signed({1'b0, w_b}) - $signed({1'b0, w_r});
        end else begin
            n_a_sec  = r2hsv_pkg::SEC_BLUE;
            n_a_diff = $signed({1'b0, w_r}) - $signed({1'b0, w_g});
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else begin
            r_a_valid <= i_start && !o_busy;
        end
        r_a_max  <= n_a_max;
        r_a_min  <= n_a_min;
        r_a_sec  <= n_a_sec;
        r_a_diff <= n_a_diff;
    end

    // ------------------------------------------------------------------
    // stage b: delta, hue numerator in sixths of a turn, divider operands
    // ------------------------------------------------------------------
    r2hsv_pkg::t_comp        w_delta;
    logic signed [HW:0]      w_delta_x;
    logic signed [HW:0]      w_base;
    logic signed [HW:0]      w_num;
    logic [2*CB-1:0]         w_sat_num;
    t_div_stage              n_pipe [0:CB];
    t_div_stage              r_pipe [0:CB];

    always_comb begin
        w_delta   = r_a_max - r_a_min;
        w_delta_x = $signed({4'b0, w_delta});
        case (r_a_sec)
            r2hsv_pkg::SEC_RED: begin
                // negative angle wraps by one full turn
                w_base = (r_a_diff < 0) ? (w_delta_x <<< 2) + (w_delta_x <<< 1)
                                        : '0;
            end
            r2hsv_pkg::SEC_GREEN: begin
                w_base = w_delta_x <<< 1;
            end
            r2hsv_pkg::SEC_BLUE: begin
                w_base = w_delta_x <<< 2;
            end
            default: begin
                w_base = '0;
            end
        endcase
        w_num     = w_base + (HW + 1)'(r_a_diff);
        // delta * full = (delta << CB) - delta
        w_sat_num = {w_delta, {CB{1'b0}}} - {{CB{1'b0}}, w_delta};

        n_pipe[0].valid = r_a_valid;
        n_pipe[0].grey  = (r_a_max == r_a_min);
        n_pipe[0].value = r_a_max;
        n_pipe[0].hrem  = w_num[HW-1:0];
        n_pipe[0].hdiv  = HW'({w_delta, 2'b0}) + HW'({w_delta, 1'b0});
        n_pipe[0].hq    = '0;
        n_pipe[0].srem  = w_sat_num[2*CB-1:CB];
        n_pipe[0].slo   = w_sat_num[CB-1:0];
        n_pipe[0].sq    = '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pipe[0].valid <= 1'b0;
        end else begin
            r_pipe[0] <= n_pipe[0];
        end
    end

    // ------------------------------------------------------------------
    // divider stages: one restoring step of each divider per stage
    // ------------------------------------------------------------------
    for (genvar k = 0; k < CB; k++) begin : g_div
        logic [HW:0] w_hsh;
        logic [CB:0] w_ssh;
        logic        w_hbit;
        logic        w_sbit;

        always_comb begin
            w_hsh  = {r_pipe[k].hrem, 1'b0};
            w_ssh  = {r_pipe[k].srem, r_pipe[k].slo[CB-1]};
            w_hbit = (w_hsh >= {1'b0, r_pipe[k].hdiv});
            w_sbit = (w_ssh >= {1'b0, r_pipe[k].value});

            n_pipe[k+1]       = r_pipe[k];
            n_pipe[k+1].hrem  = w_hbit ? HW'(w_hsh - {1'b0, r_pipe[k].hdiv})
                                       : w_hsh[HW-1:0];
            n_pipe[k+1].hq    = {r_pipe[k].hq[CB-2:0], w_hbit};
            n_pipe[k+1].srem  = w_sbit ? CB'(w_ssh - {1'b0, r_pipe[k].value})
                                       : w_ssh[CB-1:0];
            n_pipe[k+1].slo   = {r_pipe[k].slo[CB-2:0], 1'b0};
            n_pipe[k+1].sq    = {r_pipe[k].sq[CB-2:0], w_sbit};
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_pipe[k+1].valid <= 1'b0;
            end else begin
                r_pipe[k+1] <= n_pipe[k+1];
            end
        end
    end

    // ------------------------------------------------------------------
    // result: grey pixels force hue and saturation to zero
    // ------------------------------------------------------------------
    assign o_valid             = r_pipe[CB].valid;
    assign o_result.hue        = r_pipe[CB].grey ? '0 : r2hsv_pkg::t_field'(r_pipe[CB].hq);
    assign o_result.saturation = r_pipe[CB].grey ? '0 : r2hsv_pkg::t_field'(r_pipe[CB].sq);
    assign o_result.value      = r2hsv_pkg::t_field'(r_pipe[CB].value);

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    a_fixed_latency : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(i_start, r2hsv_pkg::LATENCY))
        else $error("result without a matching request");

    a_no_drop : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |-> ##(r2hsv_pkg::LATENCY) o_valid)
        else $error("request did not produce a result");

    a_div_rem : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pipe[CB].valid && !r_pipe[CB].grey) |->
            (r_pipe[CB].hrem < r_pipe[CB].hdiv) && (r_pipe[CB].srem < r_pipe[CB].value))
        else $error("divider remainder out of range");

    a_grey_hue : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_result.saturation == '0) |-> (o_result.hue == '0))
        else $error("zero saturation with nonzero hue");

endmodule

`default_nettype wire
